FILE: hdl/mea_pkg.sv
// Shared types and instruction codes for the MIPS execute ALU.
`timescale 1ns / 1ps
`default_nettype none

package mea_pkg;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_XORI  = 6'h0e;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // R-type function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    // Memory access kinds
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // Syscall service code that stops the machine
    localparam logic [31:0] HALT_CODE = 32'd10;

    // Number of shift/add steps for one multiply or divide
    localparam int MD_STEPS = 32;

    typedef struct packed {
        logic [31:0] alu_result;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [1:0]  access;
        logic [31:0] store_data;
        logic        halt;
        logic        div_by_zero;
    } result_t;

    typedef struct packed {
        logic is_div;
        logic is_signed;
    } md_ctl_t;

    typedef struct packed {
        result_t     res;
        logic        md_start;
        md_ctl_t     md_ctl;
        logic        hi_we;
        logic        lo_we;
    } dec_t;

endpackage

`default_nettype wire

FILE: hdl/mips_execute_alu_core.sv
// Top level of the MIPS32 integer execute unit with HI/LO registers.
//
//  channel | signals                                          | dir | handshake
//  --------+--------------------------------------------------+-----+--------------------------
//  item    | instruction rs_value rt_value service_code       | in  | item_valid / item_ready
//  result  | alu_result dest_reg reg_write access store_data  | out | result_valid / result_ready
//          | halt div_by_zero                                 |     |
//
//  Other ops: a request's result is registered into the output register at the accepting edge.
//  mult/multu/div/divu load the unit at the accepting edge, then run 32 steps of the
//  shared shift/add unit and a sign-fix step; HI/LO take the result at the end of the
//  fix step, and the result is posted once the output register is free. item_ready
//  stays low meanwhile.
//  A divide by zero does not start the shift/add unit and leaves HI/LO unchanged.
//  Reset clears HI, LO, the sequencer and the result valid flag.
//  A stalled result holds in the output register; while no multiply/divide is in
//  progress, a new request is taken once that register is free or drained that cycle.
`timescale 1ns / 1ps
`default_nettype none

module mips_execute_alu_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [31:0] instruction,
    input  wire logic [31:0] rs_value,
    input  wire logic [31:0] rt_value,
    input  wire logic [31:0] service_code,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [31:0]      alu_result,
    output logic [4:0]       dest_reg,
    output logic             reg_write,
    output logic [1:0]       access,
    output logic [31:0]      store_data,
    output logic             halt,
    output logic             div_by_zero
);
    import mea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,   // free for a new request
        S_BUSY = 3'b010,   // multiply/divide in progress
        S_DONE = 3'b100    // HI/LO updated, waiting for the output register
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic        valid_reg, valid_next;
    result_t     out_reg, out_next;
    result_t     pend_reg, pend_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;

    dec_t        dec;
    logic        accept;
    logic        slot_free;
    logic        md_start;
    logic        md_done;
    logic [31:0] md_hi;
    logic [31:0] md_lo;

    mea_decode u_decode (
        .instruction  (instruction),
        .rs_value     (rs_value),
        .rt_value     (rt_value),
        .service_code (service_code),
        .hi_word      (hi_reg),
        .lo_word      (lo_reg),
        .dec          (dec)
    );

    mea_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .ctl    (dec.md_ctl),
        .op_a   (rs_value),
        .op_b   (rt_value),
        .done   (md_done),
        .hi_out (md_hi),
        .lo_out (md_lo)
    );

    // output register is free when empty or being drained this cycle
    assign slot_free  = !valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE) && slot_free;
    assign accept     = item_valid && item_ready;
    assign md_start   = accept && dec.md_start;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        pend_next  = pend_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;

        // drop the posted result once taken
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (dec.md_start)
                    begin
                        // hold the result fields until HI/LO are done
                        pend_next  = dec.res;
                        state_next = S_BUSY;
                    end
                    else
                    begin
                        out_next   = dec.res;
                        valid_next = 1'b1;
                    end
                    if (dec.hi_we)
                    begin
                        hi_next = rs_value;
                    end
                    if (dec.lo_we)
                    begin
                        lo_next = rs_value;
                    end
                end
            end
            S_BUSY:
            begin
                if (md_done)
                begin
                    hi_next    = md_hi;
                    lo_next    = md_lo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_next   = pend_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result_valid = valid_reg;
    assign alu_result   = out_reg.alu_result;
    assign dest_reg     = out_reg.dest_reg;
    assign reg_write    = out_reg.reg_write;
    assign access       = out_reg.access;
    assign store_data   = out_reg.store_data;
    assign halt         = out_reg.halt;
    assign div_by_zero  = out_reg.div_by_zero;

    // the iterative unit only finishes while the sequencer waits on it
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_BUSY))
        else $error("multiply/divide finished outside busy state");

    // HI/LO move only on a request or at the end of a multiply/divide
    a_hilo_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(hi_reg) || !$stable(lo_reg)) |->
            ($past(accept) || $past(md_done)))
        else $error("HI/LO changed without a source");

    // a new result is posted only after a request or a finished multiply/divide
    a_post_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> ($past(accept) || $past(state_reg == S_DONE)))
        else $error("result posted without a request");

    // a finished multiply/divide is posted, and the sequencer goes idle, once the output register is free
    a_done_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> (state_reg == S_IDLE && valid_reg))
        else $error("finished multiply/divide not posted");

endmodule

`default_nettype wire

FILE: hdl/mea_decode.sv
// Instruction decode and combinational integer operations.
`timescale 1ns / 1ps
`default_nettype none

module mea_decode (
    input  wire logic [31:0] instruction,
    input  wire logic [31:0] rs_value,
    input  wire logic [31:0] rt_value,
    input  wire logic [31:0] service_code,
    input  wire logic [31:0] hi_word,
    input  wire logic [31:0] lo_word,
    output mea_pkg::dec_t    dec
);
    import mea_pkg::*;

    logic [5:0]  opcode;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  shamt;
    logic [5:0]  funct;
    logic [31:0] simm;
    logic [31:0] zimm;

    assign opcode = instruction[31:26];
    assign rt     = instruction[20:16];
    assign rd     = instruction[15:11];
    assign shamt  = instruction[10:6];
    assign funct  = instruction[5:0];
    assign simm   = {{16{instruction[15]}}, instruction[15:0]};
    assign zimm   = {16'h0000, instruction[15:0]};

    always_comb
    begin
        dec = '0;
        if (instruction != '0)
        begin
            if (opcode == OP_RTYPE)
            begin
                dec.res.dest_reg  = rd;
                dec.res.reg_write = 1'b1;
                unique case (funct)
                    FN_ADD, FN_ADDU: dec.res.alu_result = rs_value + rt_value;
                    FN_SUB, FN_SUBU: dec.res.alu_result = rs_value - rt_value;
                    FN_AND:  dec.res.alu_result = rs_value & rt_value;
                    FN_OR:   dec.res.alu_result = rs_value | rt_value;
                    FN_XOR:  dec.res.alu_result = rs_value ^ rt_value;
                    FN_NOR:  dec.res.alu_result = ~(rs_value | rt_value);
                    FN_SLT:  dec.res.alu_result =
                                 {31'd0, $signed(rs_value) < $signed(rt_value)};
                    FN_SLTU: dec.res.alu_result = {31'd0, rs_value < rt_value};
                    FN_SLL:  dec.res.alu_result = rt_value << shamt;
                    FN_SRL:  dec.res.alu_result = rt_value >> shamt;
                    FN_SRA:  dec.res.alu_result = $unsigned($signed(rt_value) >>> shamt);
                    FN_MFHI: dec.res.alu_result = hi_word;
                    FN_MFLO: dec.res.alu_result = lo_word;
                    FN_MTHI:
                    begin
                        dec.res.reg_write = 1'b0;
                        dec.hi_we         = 1'b1;
                    end
                    FN_MTLO:
                    begin
                        dec.res.reg_write = 1'b0;
                        dec.lo_we         = 1'b1;
                    end
                    FN_MULT, FN_MULTU:
                    begin
                        dec.res.reg_write    = 1'b0;
                        dec.md_start         = 1'b1;
                        dec.md_ctl.is_div    = 1'b0;
                        dec.md_ctl.is_signed = (funct == FN_MULT);
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        dec.res.reg_write = 1'b0;
                        // zero divisor: flag it and leave HI/LO alone
                        if (rt_value == '0)
                        begin
                            dec.res.div_by_zero = 1'b1;
                        end
                        else
                        begin
                            dec.md_start         = 1'b1;
                            dec.md_ctl.is_div    = 1'b1;
                            dec.md_ctl.is_signed = (funct == FN_DIV);
                        end
                    end
                    FN_SYSCALL:
                    begin
                        dec.res.reg_write = 1'b0;
                        dec.res.halt      = (service_code == HALT_CODE);
                    end
                    default: dec.res.reg_write = 1'b0;
                endcase
            end
            else
            begin
                dec.res.dest_reg  = rt;
                dec.res.reg_write = 1'b1;
                unique case (opcode)
                    OP_ADDI, OP_ADDIU: dec.res.alu_result = rs_value + simm;
                    OP_ANDI: dec.res.alu_result = rs_value & zimm;
                    OP_ORI:  dec.res.alu_result = rs_value | zimm;
                    OP_XORI: dec.res.alu_result = rs_value ^ zimm;
                    OP_LUI:  dec.res.alu_result = {instruction[15:0], 16'h0000};
                    OP_SLTI: dec.res.alu_result =
                                 {31'd0, $signed(rs_value) < $signed(simm)};
                    OP_LW:
                    begin
                        dec.res.alu_result = rs_value + simm;
                        dec.res.access     = ACC_LOAD;
                        dec.res.reg_write  = 1'b0;
                    end
                    OP_SW:
                    begin
                        dec.res.alu_result = rs_value + simm;
                        dec.res.access     = ACC_STORE;
                        dec.res.store_data = rt_value;
                        dec.res.reg_write  = 1'b0;
                    end
                    default: dec.res.reg_write = 1'b0;
                endcase
            end
            if (dec.res.dest_reg == '0)
            begin
                dec.res.reg_write = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mea_muldiv.sv
// Iterative multiply/divide unit built around one shared 34-bit adder.
`timescale 1ns / 1ps
`default_nettype none

module mea_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire mea_pkg::md_ctl_t ctl,
    input  wire logic [31:0]     op_a,
    input  wire logic [31:0]     op_b,
    output logic                 done,
    output logic [31:0]          hi_out,
    output logic [31:0]          lo_out
);
    import mea_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_STEP = 3'b010,
        M_FIX  = 3'b100
    } md_state_t;

    localparam logic [4:0] LAST_STEP = 5'(MD_STEPS - 1);

    md_state_t   state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        is_div_reg, is_div_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] div_reg, div_next;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [33:0] add_x;
    logic [33:0] add_y;
    logic        add_sub;
    logic [33:0] add_sum;
    logic [63:0] prod_neg;

    // operand magnitudes for the signed forms
    assign mag_a = (ctl.is_signed && op_a[31]) ? (32'd0 - op_a) : op_a;
    assign mag_b = (ctl.is_signed && op_b[31]) ? (32'd0 - op_b) : op_b;

    // shared adder: add multiplicand, or trial-subtract divisor
    always_comb
    begin
        if (is_div_reg)
        begin
            add_x   = {1'b0, hi_reg, lo_reg[31]};
            add_y   = {2'b00, div_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_x   = {2'b00, hi_reg};
            add_y   = lo_reg[0] ? {2'b00, div_reg} : 34'd0;
            add_sub = 1'b0;
        end
        add_sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};
    end

    assign prod_neg = 64'd0 - {hi_reg, lo_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        is_div_next = is_div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        div_next    = div_reg;
        done        = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next  = M_STEP;
                    cnt_next    = '0;
                    is_div_next = ctl.is_div;
                    neg_q_next  = ctl.is_signed && (op_a[31] ^ op_b[31]);
                    neg_r_next  = ctl.is_signed && op_a[31];
                    hi_next     = '0;
                    lo_next     = mag_a;
                    div_next    = mag_b;
                end
            end
            M_STEP:
            begin
                if (is_div_reg)
                begin
                    // restoring step: keep the difference unless it borrowed
                    if (add_sum[33])
                    begin
                        hi_next = add_x[31:0];
                        lo_next = {lo_reg[30:0], 1'b0};
                    end
                    else
                    begin
                        hi_next = add_sum[31:0];
                        lo_next = {lo_reg[30:0], 1'b1};
                    end
                end
                else
                begin
                    hi_next = add_sum[32:1];
                    lo_next = {add_sum[0], lo_reg[31:1]};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = M_FIX;
                end
            end
            M_FIX:
            begin
                if (is_div_reg)
                begin
                    if (neg_q_reg)
                    begin
                        lo_next = 32'd0 - lo_reg;
                    end
                    if (neg_r_reg)
                    begin
                        hi_next = 32'd0 - hi_reg;
                    end
                end
                else if (neg_q_reg)
                begin
                    {hi_next, lo_next} = prod_neg;
                end
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
        if (state_reg == M_FIX)
        begin
            done = 1'b1;
        end
    end

    // corrected values show during the fix state, alongside done
    assign hi_out = hi_next;
    assign lo_out = lo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        div_reg    <= div_next;
    end

endmodule

`default_nettype wire

FILE: tb/sv/mips_execute_alu_core_tb.sv
// Self-checking testbench for the MIPS32 execute ALU with HI/LO registers.
`timescale 1ns / 1ps

module mips_execute_alu_core_tb;

    import mea_pkg::*;

    // Codes that decode to nothing, used to reach the unknown-instruction path
    localparam logic [5:0] FN_UNUSED = 6'h3f;
    localparam logic [5:0] OP_UNUSED = 6'h3f;

    // Receiver hold-off length for the back-pressure test, in cycles
    localparam int HOLD_CYCLES = 240;
    // Cycles with no request or result moving before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // Settle time after the last result; covers a full multiply/divide pass
    localparam int TAIL_CYCLES = 40;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    logic [31:0] instruction  = '0;
    logic [31:0] rs_value     = '0;
    logic [31:0] rt_value     = '0;
    logic [31:0] service_code = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] alu_result;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic [1:0]  access;
    logic [31:0] store_data;
    logic        halt;
    logic        div_by_zero;

    // A directed row may carry a hand-written expectation; it travels with the
    // request payload so the monitor sees it at the accepting edge.
    logic        row_pinned = 1'b0;
    result_t     row_want   = '0;

    typedef struct {
        logic [31:0] word;
        logic [31:0] src_a;
        logic [31:0] src_b;
        logic [31:0] svc;
        bit          pinned;
        result_t     want;
    } stim_row_t;

    stim_row_t   directed_rows[$];
    result_t     pending_results[$];
    logic [5:0]  funct_pool[$];
    logic [5:0]  opcode_pool[$];

    // Shadow copies of HI and LO, advanced as requests are accepted
    logic [31:0] hi_shadow = '0;
    logic [31:0] lo_shadow = '0;

    int          errors        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_ask      = 0;
    int          holds_served  = 0;
    int          stall_cycles  = 0;

    mips_execute_alu_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Compute the result of one instruction and advance the HI/LO shadows.
    function automatic result_t execute_word(input logic [31:0] word, input logic [31:0] a,
                                             input logic [31:0] b, input logic [31:0] svc);
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  sh;
        logic [31:0] imm_s;
        logic [31:0] imm_z;
        logic [63:0] prod;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quot;
        logic [31:0] rem;
        result_t     r;

        r     = '0;
        opc   = word[31:26];
        fn    = word[5:0];
        sh    = word[10:6];
        imm_z = {16'h0000, word[15:0]};
        imm_s = {{16{word[15]}}, word[15:0]};
        if (word != '0)
        begin
            if (opc == OP_RTYPE)
            begin
                r.dest_reg  = word[15:11];
                r.reg_write = 1'b1;
                case (fn)
                    FN_ADD, FN_ADDU: r.alu_result = a + b;
                    FN_SUB, FN_SUBU: r.alu_result = a - b;
                    FN_AND:          r.alu_result = a & b;
                    FN_OR:           r.alu_result = a | b;
                    FN_XOR:          r.alu_result = a ^ b;
                    FN_NOR:          r.alu_result = ~(a | b);
                    FN_SLT:          r.alu_result = {31'b0, $signed(a) < $signed(b)};
                    FN_SLTU:         r.alu_result = {31'b0, a < b};
                    FN_SLL:          r.alu_result = b << sh;
                    FN_SRL:          r.alu_result = b >> sh;
                    FN_SRA:          r.alu_result = $signed(b) >>> sh;
                    FN_MFHI:         r.alu_result = hi_shadow;
                    FN_MFLO:         r.alu_result = lo_shadow;
                    FN_MTHI:
                    begin
                        hi_shadow   = a;
                        r.reg_write = 1'b0;
                    end
                    FN_MTLO:
                    begin
                        lo_shadow   = a;
                        r.reg_write = 1'b0;
                    end
                    FN_MULT, FN_MULTU:
                    begin
                        if (fn == FN_MULT)
                            prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        else
                            prod = {32'h0, a} * {32'h0, b};
                        hi_shadow   = prod[63:32];
                        lo_shadow   = prod[31:0];
                        r.reg_write = 1'b0;
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        r.reg_write = 1'b0;
                        if (b == '0)
                            r.div_by_zero = 1'b1;
                        else if (fn == FN_DIV)
                        begin
                            // Divide magnitudes, then fix signs; covers the
                            // most-negative by minus-one overflow without trapping.
                            mag_a     = a[31] ? -a : a;
                            mag_b     = b[31] ? -b : b;
                            quot      = mag_a / mag_b;
                            rem       = mag_a % mag_b;
                            lo_shadow = (a[31] ^ b[31]) ? -quot : quot;
                            hi_shadow = a[31] ? -rem : rem;
                        end
                        else
                        begin
                            lo_shadow = a / b;
                            hi_shadow = a % b;
                        end
                    end
                    FN_SYSCALL:
                    begin
                        r.reg_write = 1'b0;
                        r.halt      = (svc == HALT_CODE);
                    end
                    default: r.reg_write = 1'b0;
                endcase
            end
            else
            begin
                r.dest_reg  = word[20:16];
                r.reg_write = 1'b1;
                case (opc)
                    OP_ADDI, OP_ADDIU: r.alu_result = a + imm_s;
                    OP_ANDI:           r.alu_result = a & imm_z;
                    OP_ORI:            r.alu_result = a | imm_z;
                    OP_XORI:           r.alu_result = a ^ imm_z;
                    OP_LUI:            r.alu_result = {word[15:0], 16'h0000};
                    OP_SLTI:           r.alu_result = {31'b0, $signed(a) < $signed(imm_s)};
                    OP_LW:
                    begin
                        r.alu_result = a + imm_s;
                        r.access     = ACC_LOAD;
                        r.reg_write  = 1'b0;
                    end
                    OP_SW:
                    begin
                        r.alu_result = a + imm_s;
                        r.access     = ACC_STORE;
                        r.store_data = b;
                        r.reg_write  = 1'b0;
                    end
                    default: r.reg_write = 1'b0;
                endcase
            end
            // Register zero is never written
            if (r.dest_reg == '0)
                r.reg_write = 1'b0;
        end
        return r;
    endfunction

    function automatic result_t res_of(input logic [31:0] alu, input logic [4:0] dest,
                                       input logic wr, input logic [1:0] acc,
                                       input logic [31:0] sdata, input logic hlt,
                                       input logic dz);
        result_t r;

        r.alu_result  = alu;
        r.dest_reg    = dest;
        r.reg_write   = wr;
        r.access      = acc;
        r.store_data  = sdata;
        r.halt        = hlt;
        r.div_by_zero = dz;
        return r;
    endfunction

    // R-type word with random rs/rt index fields
    function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rd,
                                           input logic [4:0] sh);
        return {OP_RTYPE, 10'($urandom), rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] opc, input logic [4:0] rt,
                                           input logic [15:0] imm);
        return {opc, 5'($urandom), rt, imm};
    endfunction

    function automatic void add_row(input logic [31:0] word, input logic [31:0] a,
                                    input logic [31:0] b, input logic [31:0] svc,
                                    input bit pinned, input result_t want);
        stim_row_t row;

        row.word   = word;
        row.src_a  = a;
        row.src_b  = b;
        row.svc    = svc;
        row.pinned = pinned;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // Favor the corners of 32-bit arithmetic, otherwise anything goes
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Offer one request, idling first at the current sender rate; return at
    // the edge that accepts it. Valid is never lowered and raised in one step.
    task automatic send_request(input logic [31:0] word, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] svc,
                                input bit pinned, input result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        instruction  <= word;
        rs_value     <= a;
        rt_value     <= b;
        service_code <= svc;
        row_pinned   <= pinned;
        row_want     <= want;
        do
            @(posedge clk);
        while (!(item_valid && item_ready));
    endtask

    // Build one well-formed instruction with random fields, or now and then raw
    // noise. Multiply/divide is often followed by reads of HI and LO.
    task automatic send_random();
        logic [31:0] word;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] svc;
        logic [5:0]  code;
        int          pick;

        pick = $urandom_range(0, 99);
        a    = pick_operand();
        b    = pick_operand();
        svc  = ($urandom_range(0, 2) == 0) ? HALT_CODE : $urandom;
        word = $urandom;
        code = FN_UNUSED;
        if (pick < 52)
        begin
            code          = funct_pool[$urandom_range(0, funct_pool.size() - 1)];
            word[31:26]   = OP_RTYPE;
            word[5:0]     = code;
            if (code == FN_DIV || code == FN_DIVU)
            begin
                case ($urandom_range(0, 5))
                    0:       b = '0;
                    1:
                    begin
                        a = 32'h8000_0000;
                        b = '1;
                    end
                    default: ;
                endcase
            end
        end
        else if (pick < 92)
            word[31:26] = opcode_pool[$urandom_range(0, opcode_pool.size() - 1)];
        send_request(word, a, b, svc, 1'b0, '0);
        if (pick < 52 && (code == FN_MULT || code == FN_MULTU || code == FN_DIV ||
                          code == FN_DIVU || code == FN_MTHI || code == FN_MTLO) &&
            $urandom_range(0, 1) == 1)
        begin
            send_request(r_word(FN_MFHI, 5'($urandom), 5'($urandom)), $urandom, $urandom,
                         $urandom, 1'b0, '0);
            send_request(r_word(FN_MFLO, 5'($urandom), 5'($urandom)), $urandom, $urandom,
                         $urandom, 1'b0, '0);
        end
    endtask

    // Drop valid and hold off until every pending result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver: stall at the current rate, or hold off a long stretch on demand
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_ask != holds_served)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check each accepted result against the oldest expectation first,
    // then queue the prediction for a request accepted at the same edge.
    always @(posedge clk)
    begin : track_results
        result_t want;
        result_t predicted;

        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none pending, expected nothing, actual %h",
                             $time, alu_result);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("alu_result", want.alu_result, alu_result);
                    check_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
                    check_field("reg_write", 32'(want.reg_write), 32'(reg_write));
                    check_field("access", 32'(want.access), 32'(access));
                    check_field("store_data", want.store_data, store_data);
                    check_field("halt", 32'(want.halt), 32'(halt));
                    check_field("div_by_zero", 32'(want.div_by_zero), 32'(div_by_zero));
                end
            end
            if (item_valid && item_ready)
            begin
                predicted = execute_word(instruction, rs_value, rt_value, service_code);
                pending_results.push_back(row_pinned ? row_want : predicted);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        funct_pool  = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
                        FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_SRA, FN_MFHI, FN_MFLO, FN_MTHI,
                        FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_SYSCALL, FN_UNUSED};
        opcode_pool = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                        OP_LW, OP_SW, OP_UNUSED};

        // HI and LO read back as zero straight after reset
        add_row(r_word(FN_MFHI, 5'd3, 5'd0), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h0, 5'd3, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_MFLO, 5'd4, 5'd0), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h0, 5'd4, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // An all-zero word is a no-op whatever the operands
        add_row(32'h0, '1, '1, HALT_CODE, 1'b1, '0);
        // Add and subtract wrap with no trap
        add_row(r_word(FN_ADDU, 5'd5, 5'd0), '1, 32'h1, $urandom, 1'b1,
                res_of(32'h0, 5'd5, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_ADD, 5'd6, 5'd0), 32'h7FFF_FFFF, 32'h1, $urandom, 1'b1,
                res_of(32'h8000_0000, 5'd6, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_SUB, 5'd7, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_SUBU, 5'd8, 5'd0), 32'h0, 32'h1, $urandom, 1'b1,
                res_of('1, 5'd8, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_AND, 5'd9, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_OR, 5'd10, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_XOR, 5'd11, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_NOR, 5'd12, 5'd0), 32'h0, 32'h0, $urandom, 1'b1,
                res_of('1, 5'd12, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Signed and unsigned compares disagree on the sign bit
        add_row(r_word(FN_SLT, 5'd13, 5'd0), 32'h8000_0000, 32'h7FFF_FFFF, $urandom, 1'b1,
                res_of(32'h1, 5'd13, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_SLTU, 5'd14, 5'd0), 32'h8000_0000, 32'h7FFF_FFFF, $urandom, 1'b1,
                res_of(32'h0, 5'd14, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Largest shift amounts
        add_row(r_word(FN_SLL, 5'd15, 5'd31), '1, 32'h1, $urandom, 1'b1,
                res_of(32'h8000_0000, 5'd15, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_SRL, 5'd16, 5'd31), '1, 32'h8000_0000, $urandom, 1'b1,
                res_of(32'h1, 5'd16, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_SRA, 5'd17, 5'd31), '1, 32'h8000_0000, $urandom, 1'b1,
                res_of('1, 5'd17, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Multiply extremes, read back through HI/LO
        add_row(r_word(FN_MULT, 5'd1, 5'd0), '1, '1, $urandom, 1'b0, '0);
        add_row(r_word(FN_MFLO, 5'd18, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_MULTU, 5'd2, 5'd0), '1, '1, $urandom, 1'b0, '0);
        add_row(r_word(FN_MFHI, 5'd19, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        // Signed division overflow: quotient stays most-negative, remainder zero
        add_row(r_word(FN_DIV, 5'd3, 5'd0), 32'h8000_0000, '1, $urandom, 1'b0, '0);
        add_row(r_word(FN_MFHI, 5'd20, 5'd0), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h0, 5'd20, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Zero divisor raises the flag and leaves HI/LO alone
        add_row(r_word(FN_DIVU, 5'd21, 5'd0), $urandom, 32'h0, $urandom, 1'b1,
                res_of(32'h0, 5'd21, 1'b0, ACC_NONE, 32'h0, 1'b0, 1'b1));
        add_row(r_word(FN_MFLO, 5'd22, 5'd0), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h8000_0000, 5'd22, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(r_word(FN_MTHI, 5'd4, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_MTLO, 5'd5, 5'd0), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(r_word(FN_SYSCALL, 5'd23, 5'd0), $urandom, $urandom, HALT_CODE, 1'b1,
                res_of(32'h0, 5'd23, 1'b0, ACC_NONE, 32'h0, 1'b1, 1'b0));
        add_row(r_word(FN_UNUSED, 5'd24, 5'd0), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h0, 5'd24, 1'b0, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Register zero as destination: value still shown, write suppressed
        add_row(r_word(FN_ADDU, 5'd0, 5'd0), 32'h1, 32'h2, $urandom, 1'b1,
                res_of(32'h3, 5'd0, 1'b0, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Immediates: sign-extended for arithmetic, zero-extended for logic
        add_row(i_word(OP_ADDI, 5'd5, 16'h8000), 32'h0, $urandom, $urandom, 1'b1,
                res_of(32'hFFFF_8000, 5'd5, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(i_word(OP_ADDIU, 5'd6, 16'h7FFF), '1, $urandom, $urandom, 1'b0, '0);
        add_row(i_word(OP_SLTI, 5'd7, 16'hFFFF), 32'h8000_0000, $urandom, $urandom, 1'b0, '0);
        add_row(i_word(OP_ANDI, 5'd8, 16'hFFFF), '1, $urandom, $urandom, 1'b1,
                res_of(32'h0000_FFFF, 5'd8, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(i_word(OP_ORI, 5'd9, 16'h8000), 32'h0, $urandom, $urandom, 1'b1,
                res_of(32'h0000_8000, 5'd9, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        add_row(i_word(OP_XORI, 5'd10, 16'hFFFF), $urandom, $urandom, $urandom, 1'b0, '0);
        add_row(i_word(OP_LUI, 5'd11, 16'hFFFF), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'hFFFF_0000, 5'd11, 1'b1, ACC_NONE, 32'h0, 1'b0, 1'b0));
        // Load gives only the address; store carries rt as data
        add_row(i_word(OP_LW, 5'd12, 16'hFFFC), 32'h0000_1000, $urandom, $urandom, 1'b1,
                res_of(32'h0000_0FFC, 5'd12, 1'b0, ACC_LOAD, 32'h0, 1'b0, 1'b0));
        add_row(i_word(OP_SW, 5'd13, 16'h0004), 32'hFFFF_FFFC, 32'hDEAD_BEEF, $urandom, 1'b1,
                res_of(32'h0, 5'd13, 1'b0, ACC_STORE, 32'hDEAD_BEEF, 1'b0, 1'b0));
        add_row(i_word(OP_UNUSED, 5'd14, 16'hFFFF), $urandom, $urandom, $urandom, 1'b1,
                res_of(32'h0, 5'd14, 1'b0, ACC_NONE, 32'h0, 1'b0, 1'b0));

        // Hold reset, then release it once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: light sender gaps, heavy receiver stalls
        send_idle_pct = 15;
        recv_idle_pct = 56;
        foreach (directed_rows[i])
            send_request(directed_rows[i].word, directed_rows[i].src_a, directed_rows[i].src_b,
                         directed_rows[i].svc, directed_rows[i].pinned, directed_rows[i].want);
        repeat (120) send_random();

        // Pause the sender until every result is back
        drain_results();

        // Phase two: the other way round
        send_idle_pct = 56;
        recv_idle_pct = 15;
        repeat (120) send_random();
        drain_results();

        // Phase three: no idling, but open with a long receiver hold-off so the
        // output register fills and the block stalls its request side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask <= hold_ask + 1;
        repeat (120) send_random();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: mips_execute_alu_core.f
hdl/mea_pkg.sv
hdl/mea_decode.sv
hdl/mea_muldiv.sv
hdl/mips_execute_alu_core.sv
tb/sv/mips_execute_alu_core_tb.sv
